/* hdl/dfe_pkg.sv */
// Shared constants, types and helpers for the delimited field extractor.
`timescale 1ns / 1ps

package dfe_pkg;

    localparam int MAX_DELIM   = 4;
    localparam int FIELD_CHARS = 31;
    localparam int OFFSET_BITS = 16;

    localparam int WIN_DEPTH    = (MAX_DELIM > 1) ? MAX_DELIM - 1 : 1;
    localparam int WIN_IDX_BITS = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int FILL_BITS    = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
    localparam int LEN_BITS     = $clog2(MAX_DELIM + 1);
    localparam int CHARS_BITS   = $clog2(FIELD_CHARS + 1);

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELIM_BYTES  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELIM_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIELD_NUMBER = 2'd2;

    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [31:0] DELIM_BYTES_RESET  = 32'd44;
    localparam logic [2:0]  DELIM_LENGTH_RESET = 3'd1;
    localparam logic [7:0]  FIELD_NUMBER_RESET = 8'd0;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_BAD
    } phase_t;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        phase_t                phase;
        logic [31:0]           magnitude;
        logic                  overflow;
        logic                  negative;
        logic [CHARS_BITS-1:0] chars;
    } parse_t;

    localparam parse_t PARSE_RESET = '{
        phase:     PH_SPACE,
        magnitude: 32'd0,
        overflow:  1'b0,
        negative:  1'b0,
        chars:     '0
    };

    // Result as it is queued; the signed value is formed at the output.
    typedef struct packed {
        logic        status;
        logic        num_ok;
        logic        negative;
        logic [31:0] magnitude;
        logic [15:0] offset;
    } result_t;

    function automatic logic [7:0] delim_byte(input logic [31:0] bytes, input int k);
        logic [7:0] r;
        r = 8'd0;
        if (k < 4)
            r = bytes[8*k +: 8];
        return r;
    endfunction

    function automatic result_t found_result(input parse_t p,
                                             input logic [OFFSET_BITS-1:0] start);
        result_t r;
        r.status    = STATUS_FOUND;
        r.num_ok    = (p.phase == PH_DIGITS) && !p.overflow
                      && (p.negative || !p.magnitude[31]);
        r.negative  = p.negative;
        r.magnitude = p.magnitude;
        r.offset    = 16'(start);
        return r;
    endfunction

    function automatic result_t range_result();
        result_t r;
        r.status    = STATUS_RANGE;
        r.num_ok    = 1'b0;
        r.negative  = 1'b0;
        r.magnitude = 32'd0;
        r.offset    = 16'd0;
        return r;
    endfunction

endpackage

/* hdl/dfe_digit_parser.sv */
// One character step of the decimal parser: whitespace, sign, digits.
`timescale 1ns / 1ps

module dfe_digit_parser (
    input  dfe_pkg::parse_t cur,
    input  logic [7:0]      char_in,
    input  logic            enable,
    output dfe_pkg::parse_t nxt
);
    import dfe_pkg::*;

    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic [35:0] scaled;
    parse_t      with_digit;

    assign is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);
    assign is_space = (char_in == 8'h20) || ((char_in >= 8'h09) && (char_in <= 8'h0d));
    assign digit    = char_in[3:0];

    // Ten times the magnitude plus the digit, as two shifts and two adds.
    assign scaled = {1'b0, cur.magnitude, 3'b000} + {3'b000, cur.magnitude, 1'b0}
                    + {32'd0, digit};

    always_comb
    begin
        with_digit       = cur;
        with_digit.phase = PH_DIGITS;
        if (!cur.overflow)
        begin
            if (scaled > 36'h0_8000_0000)
                with_digit.overflow = 1'b1;
            else
                with_digit.magnitude = scaled[31:0];
        end
    end

    always_comb
    begin
        nxt = cur;
        if (enable && (int'(cur.chars) < FIELD_CHARS))
        begin
            nxt.chars = cur.chars + 1'b1;
            case (cur.phase)
                PH_SPACE:
                begin
                    if (is_space)
                        nxt.phase = PH_SPACE;
                    else if ((char_in == 8'h2b) || (char_in == 8'h2d))
                    begin
                        nxt.negative = (char_in == 8'h2d);
                        nxt.phase    = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        nxt       = with_digit;
                        nxt.chars = cur.chars + 1'b1;
                    end
                    else
                        nxt.phase = PH_BAD;
                end
                PH_SIGN, PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        nxt       = with_digit;
                        nxt.chars = cur.chars + 1'b1;
                    end
                    else
                        nxt.phase = PH_BAD;
                end
                default:
                    nxt.phase = cur.phase;
            endcase
        end
    end

endmodule

/* hdl/delimited_field_extractor.sv */
// Top level: delimiter matching, field selection and the result queue.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | text_byte, end_of_string
//  output   | out_valid / out_ready| status, field_value, field_offset
//  config   | cfg_we               | cfg_index, cfg_data
//
// One word is taken per cycle while in_ready is high; the result of the word that ends the
// field is registered into the output queue. When a string ends with delimiter candidates
// still held in the match window and the field is wanted, the parser drains them one per
// cycle while the skid entry is free (up to MAX_DELIM - 1 bytes) with in_ready low. A
// two-entry output queue (register plus skid) lets input keep flowing while a result
// waits; apart from a drain, in_ready drops only while the skid entry is occupied.
// Reset clears all string state and restores the register defaults.
`timescale 1ns / 1ps

module delimited_field_extractor (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dfe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [31:0]                          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           text_byte,
    input  logic                                 end_of_string,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 status,
    output logic signed [31:0]                   field_value,
    output logic [15:0]                          field_offset
);
    import dfe_pkg::*;

    logic [31:0] delim_bytes_reg;
    logic [2:0]  delim_length_reg;
    logic [7:0]  field_number_reg;

    ctrl_state_t             state_reg, state_next;
    logic [7:0]              win_reg [WIN_DEPTH];
    logic [7:0]              win_next [WIN_DEPTH];
    logic [FILL_BITS-1:0]    fill_reg, fill_next;
    logic [7:0]              passed_reg, passed_next;
    logic [OFFSET_BITS-1:0]  pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]  seg_reg, seg_next;
    parse_t                  parse_reg, parse_next;
    logic                    answered_reg, answered_next;
    logic [WIN_IDX_BITS-1:0] flush_idx_reg, flush_idx_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg, skid_next;

    logic [LEN_BITS-1:0] len_eff;
    logic                full;
    logic                matched;
    logic [7:0]          last_delim;
    logic                in_fire;
    logic                out_pop;
    logic [7:0]          feed_byte;
    logic                feed_en;
    parse_t              parsed;
    logic                push;
    result_t             push_res;
    logic                clear_all;

    // Delimiter length with zero read as one and large values held at MAX_DELIM.
    always_comb
    begin
        if (delim_length_reg == 3'd0)
            len_eff = LEN_BITS'(1);
        else if (int'(delim_length_reg) > MAX_DELIM)
            len_eff = LEN_BITS'(MAX_DELIM);
        else
            len_eff = LEN_BITS'(delim_length_reg);
    end

    always_comb
    begin
        last_delim = 8'd0;
        for (int k = 0; k < MAX_DELIM; k++)
            if (int'(len_eff) == k + 1)
                last_delim = delim_byte(delim_bytes_reg, k);
    end

    always_comb
    begin
        full    = (int'(fill_reg) >= int'(len_eff) - 1);
        matched = full && (text_byte == last_delim);
        for (int i = 0; i < WIN_DEPTH; i++)
            if ((i + 1 < int'(len_eff)) && (win_reg[i] != delim_byte(delim_bytes_reg, i)))
                matched = 1'b0;
    end

    assign in_ready = (state_reg == ST_RUN) && !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_pop  = out_valid_reg && out_ready;

    always_comb
    begin
        if (state_reg == ST_FLUSH)
        begin
            feed_byte = win_reg[flush_idx_reg];
            feed_en   = 1'b1;
        end
        else
        begin
            feed_byte = (len_eff > LEN_BITS'(1)) ? win_reg[0] : text_byte;
            feed_en   = in_fire && !answered_reg && full && !matched;
        end
    end

    dfe_digit_parser u_parser (
        .cur     (parse_reg),
        .char_in (feed_byte),
        .enable  (feed_en),
        .nxt     (parsed)
    );

    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        fill_next      = fill_reg;
        passed_next    = passed_reg;
        pos_next       = pos_reg;
        seg_next       = seg_reg;
        parse_next     = parse_reg;
        answered_next  = answered_reg;
        flush_idx_next = flush_idx_reg;
        push           = 1'b0;
        push_res       = range_result();
        clear_all      = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (in_fire)
                begin
                    if (!answered_reg)
                    begin
                        if (matched)
                        begin
                            fill_next = '0;
                            if (passed_reg == field_number_reg)
                            begin
                                push          = 1'b1;
                                push_res      = found_result(parse_reg, seg_reg);
                                answered_next = 1'b1;
                            end
                            else
                            begin
                                passed_next = passed_reg + 8'd1;
                                seg_next    = pos_reg + 1'b1;
                                parse_next  = PARSE_RESET;
                            end
                        end
                        else if (full)
                        begin
                            parse_next = parsed;
                            if (len_eff > LEN_BITS'(1))
                            begin
                                for (int i = 0; i < WIN_DEPTH; i++)
                                begin
                                    if (i + 2 < int'(len_eff))
                                    begin
                                        if (i + 1 < WIN_DEPTH)
                                            win_next[i] = win_reg[i + 1];
                                    end
                                    else if (i + 2 == int'(len_eff))
                                        win_next[i] = text_byte;
                                end
                                fill_next = FILL_BITS'(len_eff - LEN_BITS'(1));
                            end
                        end
                        else
                        begin
                            if (int'(fill_reg) < WIN_DEPTH)
                                win_next[fill_reg[WIN_IDX_BITS-1:0]] = text_byte;
                            fill_next = fill_reg + 1'b1;
                        end

                        if (end_of_string && !answered_next)
                        begin
                            if ((passed_next == field_number_reg) && (fill_next != '0))
                            begin
                                // Held-back bytes still belong to the field.
                                state_next     = ST_FLUSH;
                                flush_idx_next = '0;
                            end
                            else
                            begin
                                push = 1'b1;
                                if (passed_next == field_number_reg)
                                    push_res = found_result(parse_next, seg_next);
                                else
                                    push_res = range_result();
                            end
                        end
                    end
                    pos_next = pos_reg + 1'b1;
                    if (end_of_string && (state_next == ST_RUN))
                        clear_all = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (!skid_valid_reg)
                begin
                    parse_next     = parsed;
                    flush_idx_next = flush_idx_reg + 1'b1;
                    if (FILL_BITS'(flush_idx_reg) + 1'b1 == fill_reg)
                    begin
                        push       = 1'b1;
                        push_res   = found_result(parsed, seg_reg);
                        clear_all  = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            default:
                state_next = ST_RUN;
        endcase

        if (clear_all)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
                win_next[i] = 8'd0;
            fill_next     = '0;
            passed_next   = 8'd0;
            pos_next      = '0;
            seg_next      = '0;
            parse_next    = PARSE_RESET;
            answered_next = 1'b0;
        end
    end

    // Output register with a skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = push_res;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_bytes_reg  <= DELIM_BYTES_RESET;
            delim_length_reg <= DELIM_LENGTH_RESET;
            field_number_reg <= FIELD_NUMBER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELIM_BYTES:  delim_bytes_reg  <= cfg_data;
                CFG_DELIM_LENGTH: delim_length_reg <= cfg_data[2:0];
                CFG_FIELD_NUMBER: field_number_reg <= cfg_data[7:0];
                default:          delim_bytes_reg  <= delim_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            for (int i = 0; i < WIN_DEPTH; i++)
                win_reg[i] <= 8'd0;
            fill_reg       <= '0;
            passed_reg     <= 8'd0;
            pos_reg        <= '0;
            seg_reg        <= '0;
            parse_reg      <= PARSE_RESET;
            answered_reg   <= 1'b0;
            flush_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            win_reg        <= win_next;
            fill_reg       <= fill_next;
            passed_reg     <= passed_next;
            pos_reg        <= pos_next;
            seg_reg        <= seg_next;
            parse_reg      <= parse_next;
            answered_reg   <= answered_next;
            flush_idx_reg  <= flush_idx_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign field_offset = out_reg.offset;
    assign field_value  = !out_reg.num_ok ? 32'sd0 :
                          out_reg.negative ? $signed(32'd0 - out_reg.magnitude) :
                                             $signed(out_reg.magnitude);

    // The skid entry is only ever filled behind a waiting output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // Draining never runs past the bytes held in the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (FILL_BITS'(flush_idx_reg) < fill_reg))
        else $error("flush index beyond window fill");

    // A drain always finishes with a result pushed into the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && state_next == ST_RUN) |-> push)
        else $error("flush ended without a result");

    // After a string ends the next word starts at offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_string && state_next == ST_RUN)
        |=> (pos_reg == '0) && !answered_reg && (passed_reg == 8'd0))
        else $error("string state not cleared at end of string");

    // A result is never pushed while the skid entry is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full queue");

endmodule
